// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cccv_pkg.sv =====
package cccv_pkg;

  localparam int MeasW  = 11;
  localparam int DutyW  = 8;
  localparam int PhaseW = 3;
  localparam int CfgIdxW = 3;

  localparam logic [PhaseW-1:0] PH_CHECK = 3'd0;
  localparam logic [PhaseW-1:0] PH_FAULT = 3'd1;
  localparam logic [PhaseW-1:0] PH_CC    = 3'd2;
  localparam logic [PhaseW-1:0] PH_CV    = 3'd3;
  localparam logic [PhaseW-1:0] PH_DONE  = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_MIN_BATT_V   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CC_CURRENT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CC_EXIT_V    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CV_VOLTAGE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DONE_CURRENT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DONE_VOLTAGE = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_START_DUTY   = 3'd6;

  localparam logic [MeasW-1:0] RST_MIN_BATT_V   = 11'd900;
  localparam logic [MeasW-1:0] RST_CC_CURRENT   = 11'd100;
  localparam logic [MeasW-1:0] RST_CC_EXIT_V    = 11'd1240;
  localparam logic [MeasW-1:0] RST_CV_VOLTAGE   = 11'd1260;
  localparam logic [MeasW-1:0] RST_DONE_CURRENT = 11'd19;
  localparam logic [MeasW-1:0] RST_DONE_VOLTAGE = 11'd1250;
  localparam logic [DutyW-1:0] RST_START_DUTY   = 8'd63;
  localparam logic [DutyW-1:0] RST_DUTY         = 8'd63;

  typedef struct packed {
    logic [MeasW-1:0] min_battery_voltage;
    logic [MeasW-1:0] cc_current_target;
    logic [MeasW-1:0] cc_exit_voltage;
    logic [MeasW-1:0] cv_voltage_target;
    logic [MeasW-1:0] done_current;
    logic [MeasW-1:0] done_voltage;
    logic [DutyW-1:0] start_duty;
  } cfg_t;

  typedef struct packed {
    logic [DutyW-1:0]  pwm_duty;
    logic              switch_on;
    logic              buzzer_on;
    logic [PhaseW-1:0] charge_phase;
  } res_t;

endpackage

// ===== src/cccv_cfg_regs.sv =====
module cccv_cfg_regs
  import cccv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MeasW-1:0]   cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_BATT_V:   cfg_nxt.min_battery_voltage = cfg_wdata;
        CFG_CC_CURRENT:   cfg_nxt.cc_current_target   = cfg_wdata;
        CFG_CC_EXIT_V:    cfg_nxt.cc_exit_voltage     = cfg_wdata;
        CFG_CV_VOLTAGE:   cfg_nxt.cv_voltage_target   = cfg_wdata;
        CFG_DONE_CURRENT: cfg_nxt.done_current        = cfg_wdata;
        CFG_DONE_VOLTAGE: cfg_nxt.done_voltage        = cfg_wdata;
        CFG_START_DUTY:   cfg_nxt.start_duty          = cfg_wdata[DutyW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_battery_voltage <= RST_MIN_BATT_V;
      cfg_r.cc_current_target   <= RST_CC_CURRENT;
      cfg_r.cc_exit_voltage     <= RST_CC_EXIT_V;
      cfg_r.cv_voltage_target   <= RST_CV_VOLTAGE;
      cfg_r.done_current        <= RST_DONE_CURRENT;
      cfg_r.done_voltage        <= RST_DONE_VOLTAGE;
      cfg_r.start_duty          <= RST_START_DUTY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/cccv_step.sv =====
module cccv_step
  import cccv_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [PhaseW-1:0] phase,
  input  logic [DutyW-1:0]  duty,
  input  logic [MeasW-1:0]  output_voltage,
  input  logic [MeasW-1:0]  charge_current,
  input  logic [MeasW-1:0]  battery_voltage,
  output res_t              res
);

  logic [MeasW-1:0]  meas;
  logic [MeasW-1:0]  target;
  logic [DutyW-1:0]  duty_step;
  logic [DutyW-1:0]  duty_nxt;
  logic [PhaseW-1:0] phase_nxt;

  // CC regulates on current, CV on output voltage
  assign meas   = (phase == PH_CV) ? output_voltage : charge_current;
  assign target = (phase == PH_CV) ? cfg.cv_voltage_target : cfg.cc_current_target;

  always_comb begin
    duty_step = duty;
    if (meas < target) begin
      if (duty != '1) duty_step = duty + 1'b1;
    end else if (meas > target) begin
      if (duty != '0) duty_step = duty - 1'b1;
    end
  end

  always_comb begin
    phase_nxt = phase;
    duty_nxt  = duty;
    unique case (phase)
      PH_CHECK: begin
        if (battery_voltage == '0) begin
          phase_nxt = PH_CHECK;
        end else if (battery_voltage < cfg.min_battery_voltage) begin
          phase_nxt = PH_FAULT;
        end else begin
          phase_nxt = PH_CC;
          duty_nxt  = cfg.start_duty;
        end
      end
      PH_CC: begin
        duty_nxt = duty_step;
        if (battery_voltage > cfg.cc_exit_voltage) phase_nxt = PH_CV;
      end
      PH_CV: begin
        duty_nxt = duty_step;
        if (charge_current < cfg.done_current && battery_voltage > cfg.done_voltage) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_FAULT, PH_DONE: begin
        phase_nxt = phase;
      end
      default: begin
        phase_nxt = PH_CHECK;
      end
    endcase
  end

  assign res.pwm_duty     = duty_nxt;
  assign res.switch_on    = (phase_nxt == PH_CC) || (phase_nxt == PH_CV);
  assign res.buzzer_on    = (phase_nxt == PH_DONE);
  assign res.charge_phase = phase_nxt;

endmodule

// ===== src/li_ion_cc_cv_charge_controller.sv =====
// CC/CV Li-ion charge controller. Each input transaction is one measurement
// round (output voltage, charge current, battery voltage); each produces exactly
// one output transaction with the new PWM duty, switch and buzzer state and
// charge phase. Rounds are taken at one per cycle while in_stall is low: the
// round is captured in an input register, the phase/duty update runs as
// combinational compare and +/-1 logic, and the result lands in an output
// register, which drives out_valid. Stalls on the output propagate to
// in_stall only once both registers are full. Configuration registers reset
// to their defaults and should be written only while no round is in flight.
module li_ion_cc_cv_charge_controller
  import cccv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MeasW-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MeasW-1:0]   in_output_voltage,
  input  logic [MeasW-1:0]   in_charge_current,
  input  logic [MeasW-1:0]   in_battery_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DutyW-1:0]   out_pwm_duty,
  output logic               out_switch_on,
  output logic               out_buzzer_on,
  output logic [PhaseW-1:0]  out_charge_phase
);

  cfg_t cfg;
  res_t res;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [MeasW-1:0]  s1_vout_r;
  logic [MeasW-1:0]  s1_amp_r;
  logic [MeasW-1:0]  s1_vbat_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  res_t              out_res_r;
  logic [PhaseW-1:0] phase_r;
  logic [DutyW-1:0]  duty_r;
  logic              in_acc;
  logic              s1_adv;

  cccv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cccv_step u_step (
    .cfg             (cfg),
    .phase           (phase_r),
    .duty            (duty_r),
    .output_voltage  (s1_vout_r),
    .charge_current  (s1_amp_r),
    .battery_voltage (s1_vbat_r),
    .res             (res)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_CHECK;
      duty_r      <= RST_DUTY;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        phase_r <= res.charge_phase;
        duty_r  <= res.pwm_duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_vout_r <= in_output_voltage;
      s1_amp_r  <= in_charge_current;
      s1_vbat_r <= in_battery_voltage;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pwm_duty     = out_res_r.pwm_duty;
  assign out_switch_on    = out_res_r.switch_on;
  assign out_buzzer_on    = out_res_r.buzzer_on;
  assign out_charge_phase = out_res_r.charge_phase;

endmodule

// ===== src/cccv_checker.sv =====
`include "assert_macros.svh"

module cccv_checker
  import cccv_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DutyW-1:0]   out_pwm_duty,
  input logic               out_switch_on,
  input logic               out_buzzer_on,
  input logic [PhaseW-1:0]  out_charge_phase
);

  logic                      seen_r;
  logic [PhaseW-1:0]         last_phase_r;
  logic [DutyW-1:0]          last_duty_r;
  logic                      out_acc;
  logic                      out_held;
  logic [DutyW+PhaseW+1:0]   out_bits;
  logic                      cc_to_cc;
  logic                      end_held;
  logic                      step_ok;
  logic                      flags_ok;

  assign out_acc  = out_valid && !out_stall;
  assign out_held = out_valid && out_stall;
  assign out_bits = {out_pwm_duty, out_switch_on, out_buzzer_on, out_charge_phase};
  assign cc_to_cc = seen_r && last_phase_r == PH_CC && out_charge_phase == PH_CC;
  assign end_held = !seen_r || (last_phase_r != PH_FAULT && last_phase_r != PH_DONE) ||
                    (out_charge_phase == last_phase_r && out_pwm_duty == last_duty_r);
  assign step_ok  = (out_pwm_duty == last_duty_r) ||
                    (out_pwm_duty == last_duty_r + 8'd1) ||
                    (out_pwm_duty == last_duty_r - 8'd1);
  assign flags_ok = (out_buzzer_on == (out_charge_phase == PH_DONE)) &&
                    !(out_buzzer_on && out_switch_on);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_acc) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_phase_r <= out_charge_phase;
      last_duty_r  <= out_pwm_duty;
    end
  end

  `ASSERT_CLK(a_rst_no_out, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_held |=> out_valid && $stable(out_bits), "stalled output changed")
  `ASSERT_CLK_RST(a_end_phase, clk, rst_n, out_acc |-> end_held, "left a terminal charge phase")
  `ASSERT_CLK_RST(a_cc_step, clk, rst_n, out_acc && cc_to_cc |-> step_ok, "CC duty step over one")
  `ASSERT_CLK_RST(a_flags, clk, rst_n, out_valid |-> flags_ok, "buzzer/switch disagree with phase")

endmodule

bind li_ion_cc_cv_charge_controller cccv_checker u_cccv_checker (.*);
